// File: rtl/pfe_pkg.sv
package pfe_pkg;

    localparam int CH_W         = 8;
    localparam int DIFF_W       = 9;
    localparam int NUM_CH       = 3;
    localparam int STEP_W       = 8;
    localparam int INDEX_W      = 8;
    localparam int COLOUR_W     = NUM_CH * CH_W;
    localparam int DIFF_STORE_W = NUM_CH * DIFF_W;
    localparam int DIV_STEPS    = 8;
    localparam int DIV_CNT_W    = 3;
    localparam int CHROMA_BIAS  = 128;

    typedef enum logic [1:0] {
        FUNC_WRITE      = 2'd0,
        FUNC_FADE_BEGIN = 2'd1,
        FUNC_FADE_STEP  = 2'd2,
        FUNC_READ       = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_UPDATE,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic load;
        logic div_step;
        logic update;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_step;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/pfe_in_if.sv
interface pfe_in_if;
    import pfe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic [INDEX_W-1:0]   entry_index;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
    logic [STEP_W-1:0]    steps_left;

    modport source (
        output valid, func, entry_index, red, green, blue, steps_left,
        input  ready
    );

    modport sink (
        input  valid, func, entry_index, red, green, blue, steps_left,
        output ready
    );

endinterface

// File: rtl/pfe_out_if.sv
interface pfe_out_if;
    import pfe_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [INDEX_W-1:0]   out_index;
    logic [CH_W-1:0]      out_red;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_blue;
    logic [CH_W-1:0]      luma;
    logic [CH_W-1:0]      chroma_u;
    logic [CH_W-1:0]      chroma_v;

    modport source (
        output valid, out_index, out_red, out_green, out_blue, luma, chroma_u, chroma_v,
        input  ready
    );

    modport sink (
        input  valid, out_index, out_red, out_green, out_blue, luma, chroma_u, chroma_v,
        output ready
    );

endinterface

// File: rtl/pfe_ram.sv
module pfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/pfe_ctrl.sv
module pfe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pfe_pkg::t_sts i_sts,
    output pfe_pkg::t_cmd o_cmd
);
    import pfe_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DIV_CNT_W-1:0] n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_div_cnt  = '0;
                n_state    = i_sts.is_step ? S_DIV : S_UPDATE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_UPDATE;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // Division is only ever run for an in-range fade step.
    a_div_only_for_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> i_sts.is_step)
        else $error("divider running for an item that is not a fade step");

    // Leaving the divider always follows the full set of quotient bits.
    a_div_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && $past(r_state) == S_DIV)
            |-> $past(r_div_cnt) == DIV_CNT_W'(DIV_STEPS - 1))
        else $error("division left before all quotient bits were formed");
`endif

endmodule

// File: rtl/pfe_datapath.sv
module pfe_datapath #(
    parameter int ENTRIES = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pfe_pkg::t_cmd                i_cmd,
    output pfe_pkg::t_sts                o_sts,
    input  logic [1:0]                   i_func,
    input  logic [pfe_pkg::INDEX_W-1:0]  i_entry_index,
    input  logic [pfe_pkg::CH_W-1:0]     i_red,
    input  logic [pfe_pkg::CH_W-1:0]     i_green,
    input  logic [pfe_pkg::CH_W-1:0]     i_blue,
    input  logic [pfe_pkg::STEP_W-1:0]   i_steps_left,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [pfe_pkg::INDEX_W-1:0]  o_out_index,
    output logic [pfe_pkg::CH_W-1:0]     o_out_red,
    output logic [pfe_pkg::CH_W-1:0]     o_out_green,
    output logic [pfe_pkg::CH_W-1:0]     o_out_blue,
    output logic [pfe_pkg::CH_W-1:0]     o_luma,
    output logic [pfe_pkg::CH_W-1:0]     o_chroma_u,
    output logic [pfe_pkg::CH_W-1:0]     o_chroma_v
);
    import pfe_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    // Captured item.
    t_func               r_func;
    logic [INDEX_W-1:0]  r_index;
    logic [CH_W-1:0]     r_tgt [NUM_CH];
    logic [STEP_W-1:0]   r_steps;
    logic                r_in_range;

    // One bit per entry: clear entries read as zero colour and zero difference.
    logic [ENTRIES-1:0]  r_valid;

    // Working registers of the entry being processed.
    logic [CH_W-1:0]         r_col  [NUM_CH];
    logic signed [DIFF_W-1:0] r_diff [NUM_CH];
    logic [CH_W-1:0]         r_rem  [NUM_CH];
    logic [CH_W-1:0]         r_quo  [NUM_CH];
    logic [CH_W-1:0]         n_col  [NUM_CH];
    logic signed [DIFF_W-1:0] n_diff [NUM_CH];
    logic [CH_W-1:0]         n_rem  [NUM_CH];
    logic [CH_W-1:0]         n_quo  [NUM_CH];

    // Result register.
    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_index;
    logic [CH_W-1:0]     r_out_red;
    logic [CH_W-1:0]     r_out_green;
    logic [CH_W-1:0]     r_out_blue;
    logic [CH_W-1:0]     r_out_luma;
    logic [CH_W-1:0]     r_out_chroma_u;
    logic [CH_W-1:0]     r_out_chroma_v;

    logic [AW-1:0]           w_addr;
    logic                    w_hit;
    logic                    w_wr_en;
    logic [COLOUR_W-1:0]     w_col_rd;
    logic [COLOUR_W-1:0]     w_col_wr;
    logic [DIFF_STORE_W-1:0] w_diff_rd;
    logic [DIFF_STORE_W-1:0] w_diff_wr;

    logic [CH_W-1:0]          w_ld_col  [NUM_CH];
    logic signed [DIFF_W-1:0] w_ld_diff [NUM_CH];
    logic [DIFF_W-1:0]        w_ld_neg  [NUM_CH];
    logic [CH_W-1:0]          w_ld_mag  [NUM_CH];
    logic [DIFF_W-1:0]        w_trial   [NUM_CH];
    logic [DIFF_W-1:0]        w_trial_sub [NUM_CH];
    logic                     w_fit     [NUM_CH];
    logic signed [DIFF_W:0]   w_q       [NUM_CH];
    logic signed [DIFF_W:0]   w_sum     [NUM_CH];
    logic signed [DIFF_W:0]   w_nd      [NUM_CH];

    logic [CH_W+1:0]          w_luma_sum;
    logic signed [CH_W:0]     w_rb;
    logic signed [CH_W:0]     w_rb_sh;
    logic signed [CH_W+2:0]   w_gv;
    logic signed [CH_W+2:0]   w_gv_sh;
    logic [CH_W-1:0]          w_luma;
    logic [CH_W-1:0]          w_chroma_u;
    logic [CH_W-1:0]          w_chroma_v;

    assign w_addr  = r_index[AW-1:0];
    assign w_hit   = r_in_range && r_valid[w_addr];
    assign w_wr_en = i_cmd.commit && r_in_range && (r_func != FUNC_READ);

    pfe_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (ENTRIES)
    ) u_colour_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_col_wr),
        .i_rd_addr (w_addr),
        .o_rd_data (w_col_rd)
    );

    pfe_ram #(
        .WIDTH (DIFF_STORE_W),
        .DEPTH (ENTRIES)
    ) u_diff_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_addr),
        .i_wr_data (w_diff_wr),
        .i_rd_addr (w_addr),
        .o_rd_data (w_diff_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= t_func'(i_func);
            r_index    <= i_entry_index;
            r_tgt[0]   <= i_red;
            r_tgt[1]   <= i_green;
            r_tgt[2]   <= i_blue;
            r_steps    <= (i_steps_left == '0) ? STEP_W'(1) : i_steps_left;
            r_in_range <= ({1'b0, i_entry_index} < (INDEX_W + 1)'(ENTRIES));
        end
    end

    // Per-channel arithmetic: load selection, one restoring division step and the update.
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            w_ld_col[k]    = w_hit ? w_col_rd[k*CH_W +: CH_W] : '0;
            w_ld_diff[k]   = w_hit ? $signed(w_diff_rd[k*DIFF_W +: DIFF_W]) : '0;
            w_ld_neg[k]    = -w_ld_diff[k];
            w_ld_mag[k]    = w_ld_diff[k][DIFF_W-1] ? w_ld_neg[k][CH_W-1:0]
                                                    : w_ld_diff[k][CH_W-1:0];
            w_trial[k]     = {r_rem[k], r_quo[k][CH_W-1]};
            w_trial_sub[k] = w_trial[k] - {1'b0, r_steps};
            w_fit[k]       = w_trial[k] >= {1'b0, r_steps};
            w_q[k]         = r_diff[k][DIFF_W-1] ? -$signed({2'b00, r_quo[k]})
                                                 : $signed({2'b00, r_quo[k]});
            w_sum[k]       = $signed({2'b00, r_col[k]}) + w_q[k];
            w_nd[k]        = $signed({r_diff[k][DIFF_W-1], r_diff[k]}) - w_q[k];
        end
    end

    always_comb begin
        n_col  = r_col;
        n_diff = r_diff;
        n_rem  = r_rem;
        n_quo  = r_quo;
        priority if (i_cmd.load) begin
            for (int k = 0; k < NUM_CH; k++) begin
                n_col[k]  = w_ld_col[k];
                n_diff[k] = w_ld_diff[k];
                n_quo[k]  = w_ld_mag[k];
                n_rem[k]  = '0;
            end
        end else if (i_cmd.div_step) begin
            for (int k = 0; k < NUM_CH; k++) begin
                n_rem[k] = w_fit[k] ? w_trial_sub[k][CH_W-1:0] : w_trial[k][CH_W-1:0];
                n_quo[k] = {r_quo[k][CH_W-2:0], w_fit[k]};
            end
        end else if (i_cmd.update) begin
            for (int k = 0; k < NUM_CH; k++) begin
                if (!r_in_range) begin
                    n_col[k]  = '0;
                    n_diff[k] = '0;
                end else begin
                    unique case (r_func)
                        FUNC_WRITE: begin
                            n_col[k] = r_tgt[k];
                        end
                        FUNC_FADE_BEGIN: begin
                            n_diff[k] = $signed({1'b0, r_tgt[k]} - {1'b0, r_col[k]});
                        end
                        FUNC_FADE_STEP: begin
                            priority if (w_sum[k][DIFF_W]) begin
                                n_col[k] = '0;
                            end else if (w_sum[k][CH_W]) begin
                                n_col[k] = '1;
                            end else begin
                                n_col[k] = w_sum[k][CH_W-1:0];
                            end
                            n_diff[k] = w_nd[k][DIFF_W-1:0];
                        end
                        FUNC_READ: begin
                        end
                    endcase
                end
            end
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        r_col  <= n_col;
        r_diff <= n_diff;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
    end

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            w_col_wr[k*CH_W +: CH_W]      = r_col[k];
            w_diff_wr[k*DIFF_W +: DIFF_W] = r_diff[k];
        end
    end

    // Cheap YUV form with flooring shifts.
    assign w_luma_sum = {2'b00, r_col[0]} + {2'b00, r_col[1]} + {2'b00, r_col[2]};
    assign w_luma     = w_luma_sum[CH_W+1:2];
    assign w_rb       = $signed({1'b0, r_col[0]} - {1'b0, r_col[2]});
    assign w_rb_sh    = w_rb >>> 2;
    assign w_chroma_u = CH_W'(CHROMA_BIAS) + w_rb_sh[CH_W-1:0];
    assign w_gv       = $signed({2'b00, r_col[1], 1'b0} - {3'b000, r_col[0]}
                                - {3'b000, r_col[2]});
    assign w_gv_sh    = w_gv >>> 3;
    assign w_chroma_v = CH_W'(CHROMA_BIAS) + w_gv_sh[CH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_valid[w_addr] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_index    <= r_index;
            r_out_red      <= r_col[0];
            r_out_green    <= r_col[1];
            r_out_blue     <= r_col[2];
            r_out_luma     <= w_luma;
            r_out_chroma_u <= w_chroma_u;
            r_out_chroma_v <= w_chroma_v;
        end
    end

    assign o_sts.is_step  = (r_func == FUNC_FADE_STEP) && r_in_range;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_luma      = r_out_luma;
    assign o_chroma_u  = r_out_chroma_u;
    assign o_chroma_v  = r_out_chroma_v;

`ifndef NO_ASSERTIONS
    // A result appears only from a commit.
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.commit))
        else $error("result became valid without a commit");

    // Every store write leaves its entry marked as written.
    a_entry_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_in_range && r_func != FUNC_READ) |=> r_valid[$past(w_addr)])
        else $error("written entry not marked valid");

    // An index beyond the store reports a black entry.
    a_out_of_range_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_in_range)
            |=> (r_out_red == '0 && r_out_green == '0 && r_out_blue == '0
                 && r_out_chroma_u == CH_W'(CHROMA_BIAS)))
        else $error("out-of-range index did not report a black entry");
`endif

endmodule

// File: rtl/palette_fade_engine.sv
// Palette store of ENTRIES colours with linear fades. Each input transaction names one entry and
// an operation (write colour, begin a fade toward a colour, take one fade step, read back) and
// produces exactly one result transaction carrying the entry's colour after the operation and
// its cheap YUV form. Both the colour store and the remaining-difference store read as zero after
// reset; a valid bit per entry provides this, so no clearing pass is needed and the block accepts
// work straight after reset. One item is processed at a time. A write, begin-fade or read goes
// through the store read of the registered RAM, load, update and commit before the block is ready
// again; a fade step also goes through division, because its three per-channel divisions run in
// parallel through a restoring divider that forms one quotient bit per cycle. The finished result
// sits in an output register, so the next item is accepted while it waits; the block stalls only
// when a second result is ready before the first is taken.
module palette_fade_engine #(
    parameter int ENTRIES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfe_in_if.sink    i_item,
    pfe_out_if.source o_result
);
    import pfe_pkg::*;

    // Command and status between the sequencer and the datapath.
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // The sequencer takes a transaction only when idle and walks it through read, load,
    // optional division, update and commit.
    pfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_item.ready = w_in_ready;

    // The datapath holds both stores, the per-channel dividers and the result register.
    pfe_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_func        (i_item.func),
        .i_entry_index (i_item.entry_index),
        .i_red         (i_item.red),
        .i_green       (i_item.green),
        .i_blue        (i_item.blue),
        .i_steps_left  (i_item.steps_left),
        .o_out_valid   (o_result.valid),
        .i_out_ready   (o_result.ready),
        .o_out_index   (o_result.out_index),
        .o_out_red     (o_result.out_red),
        .o_out_green   (o_result.out_green),
        .o_out_blue    (o_result.out_blue),
        .o_luma        (o_result.luma),
        .o_chroma_u    (o_result.chroma_u),
        .o_chroma_v    (o_result.chroma_v)
    );

endmodule

// File: tb/palette_fade_engine_tb.sv
`timescale 1ns / 1ps

module palette_fade_engine_tb;
    import pfe_pkg::*;

    localparam int ENTRIES         = 256;
    localparam int RANDOM_OPS      = 1500;
    // The item at this queue position waits until every earlier result has been collected.
    localparam int DRAIN_POINT     = 1100;
    // The receiver refuses results for this long once this many transactions are in.
    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 200;
    // Window of accepted transactions during which neither side idles.
    localparam int STEADY_FROM     = 600;
    localparam int STEADY_TO       = 900;
    // Time allowed at the end, comfortably longer than a fade step takes.
    localparam int SETTLE_CYCLES   = 40;
    // Longest run of cycles with no transaction on either side before the run is abandoned.
    localparam int QUIET_LIMIT     = 3000;

    // One palette operation as offered on the input channel.
    typedef struct {
        t_func               func;
        logic [INDEX_W-1:0]  index;
        logic [CH_W-1:0]     red;
        logic [CH_W-1:0]     green;
        logic [CH_W-1:0]     blue;
        logic [STEP_W-1:0]   steps;
        bit                  drain_first;
    } palette_op_t;

    // The colour and YUV view that one operation leaves behind.
    typedef struct {
        logic [INDEX_W-1:0]  index;
        logic [CH_W-1:0]     red;
        logic [CH_W-1:0]     green;
        logic [CH_W-1:0]     blue;
        logic [CH_W-1:0]     luma;
        logic [CH_W-1:0]     chroma_u;
        logic [CH_W-1:0]     chroma_v;
    } palette_view_t;

    logic clk;
    logic rst_n;

    pfe_in_if  item_bus ();
    pfe_out_if result_bus ();

    palette_fade_engine #(
        .ENTRIES (ENTRIES)
    ) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    // Our own copy of the two stores: the current colour of every entry and the signed
    // difference that is still left to fade, one per channel.
    logic        [CH_W-1:0]   shade_mem [ENTRIES][NUM_CH];
    logic signed [DIFF_W-1:0] delta_mem [ENTRIES][NUM_CH];

    palette_op_t   pending_ops[$];
    palette_view_t expected_views[$];

    int  items_accepted;
    int  results_taken;
    int  fail_count;
    int  quiet_cycles;
    int  hold_left;
    bit  hold_off_done;
    bit  item_taken;
    bit  result_taken;
    bit  drain_placed;

    always #4 clk = ~clk;

    // Neither side idles inside the steady window; outside it each idles about a third of
    // the time.
    function automatic bit idle_roll();
        if (items_accepted >= STEADY_FROM && items_accepted < STEADY_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < 33;
    endfunction

    // Applies one operation to the shadow stores and returns the view the block should
    // report for it. Division truncates toward zero, as the signed '/' of SystemVerilog
    // does; the chroma terms use arithmetic shifts, which floor.
    function automatic palette_view_t apply_palette_op(palette_op_t op);
        palette_view_t view;
        int divisor;
        int idx;
        int k;
        int d;
        int q;
        int c;
        int r;
        int g;
        int b;
        int tgt[NUM_CH];

        idx     = int'(op.index);
        divisor = (op.steps == '0) ? 1 : int'(op.steps);
        tgt[0]  = int'(op.red);
        tgt[1]  = int'(op.green);
        tgt[2]  = int'(op.blue);
        r = 0;
        g = 0;
        b = 0;

        if (idx < ENTRIES) begin
            for (k = 0; k < NUM_CH; k++) begin
                case (op.func)
                    FUNC_WRITE: begin
                        // The remaining difference is left alone, even mid-fade.
                        shade_mem[idx][k] = tgt[k][CH_W-1:0];
                    end
                    FUNC_FADE_BEGIN: begin
                        d = tgt[k] - int'(shade_mem[idx][k]);
                        delta_mem[idx][k] = d[DIFF_W-1:0];
                    end
                    FUNC_FADE_STEP: begin
                        d = int'(delta_mem[idx][k]);
                        q = d / divisor;
                        c = int'(shade_mem[idx][k]) + q;
                        // Only reachable after a write during a fade: the colour
                        // saturates, but the difference still loses the full quotient.
                        if (c < 0) begin
                            c = 0;
                        end
                        if (c > 255) begin
                            c = 255;
                        end
                        shade_mem[idx][k] = c[CH_W-1:0];
                        d = d - q;
                        delta_mem[idx][k] = d[DIFF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            r = int'(shade_mem[idx][0]);
            g = int'(shade_mem[idx][1]);
            b = int'(shade_mem[idx][2]);
        end

        view.index    = op.index;
        view.red      = r[CH_W-1:0];
        view.green    = g[CH_W-1:0];
        view.blue     = b[CH_W-1:0];
        view.luma     = 8'((r + g + b) >> 2);
        view.chroma_u = 8'(CHROMA_BIAS + ((r - b) >>> 2));
        view.chroma_v = 8'(CHROMA_BIAS + ((2 * g - r - b) >>> 3));
        return view;
    endfunction

    task automatic check_field(string field_name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field_name, want, got);
            fail_count++;
        end
    endtask

    task automatic add_op(t_func func, int idx, int red, int green, int blue, int steps,
                          bit drain_first = 1'b0);
        palette_op_t op;
        op.func        = func;
        op.index       = idx[INDEX_W-1:0];
        op.red         = red[CH_W-1:0];
        op.green       = green[CH_W-1:0];
        op.blue        = blue[CH_W-1:0];
        op.steps       = steps[STEP_W-1:0];
        op.drain_first = drain_first;
        pending_ops.push_back(op);
    endtask

    // Most traffic goes to a handful of entries so that fades build on earlier state.
    function automatic int pick_entry();
        return ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15);
    endfunction

    function automatic int any_byte();
        return $urandom_range(255);
    endfunction

    // A fade as software would run it: an optional write, a begin, then steps with a
    // count that falls by one each time. Now and then the sequence is broken by a write
    // in the middle or a zero count.
    task automatic add_fade_run();
        int idx;
        int span;
        int n;
        int i;

        idx  = pick_entry();
        if ($urandom_range(3) != 0) begin
            add_op(FUNC_WRITE, idx, any_byte(), any_byte(), any_byte(), any_byte());
        end
        add_op(FUNC_FADE_BEGIN, idx, any_byte(), any_byte(), any_byte(), any_byte());
        span = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(1, 8);
        n    = (span == 0) ? 1 : ((span < 6) ? span : $urandom_range(2, 6));
        for (i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                add_op(FUNC_WRITE, idx, any_byte(), any_byte(), any_byte(), any_byte());
            end
            add_op(FUNC_FADE_STEP, idx, any_byte(), any_byte(), any_byte(),
                   ($urandom_range(7) == 0) ? 0 : span - i);
        end
        if ($urandom_range(1) == 0) begin
            add_op(FUNC_READ, idx, any_byte(), any_byte(), any_byte(), any_byte());
        end
    endtask

    // Input side, acceptance: a transaction moves at a rising edge with valid and ready
    // both high. The prediction is made here, in acceptance order.
    always @(posedge clk) begin
        item_taken = rst_n && item_bus.valid && item_bus.ready;
        if (item_taken) begin
            expected_views.push_back(apply_palette_op(pending_ops.pop_front()));
            items_accepted++;
        end
    end

    // Input side, driving: on the falling edge an offer that has not yet been taken is
    // held as it is; otherwise the next operation is offered, unless this cycle idles or
    // the operation must wait for the output to drain.
    always @(negedge clk) begin
        if (rst_n && !(item_bus.valid && !item_taken)) begin
            if (pending_ops.size() != 0
                && !(pending_ops[0].drain_first && expected_views.size() != 0)
                && !idle_roll()) begin
                item_bus.func        <= pending_ops[0].func;
                item_bus.entry_index <= pending_ops[0].index;
                item_bus.red         <= pending_ops[0].red;
                item_bus.green       <= pending_ops[0].green;
                item_bus.blue        <= pending_ops[0].blue;
                item_bus.steps_left  <= pending_ops[0].steps;
                item_bus.valid       <= 1'b1;
            end else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    // Output side, checking: every result transaction is compared with the oldest
    // outstanding prediction.
    always @(posedge clk) begin : result_check
        palette_view_t want;
        result_taken = rst_n && result_bus.valid && result_bus.ready;
        if (result_taken) begin
            results_taken++;
            if (expected_views.size() == 0) begin
                $error("unexpected result transaction for entry %0d", result_bus.out_index);
                fail_count++;
            end else begin
                want = expected_views.pop_front();
                check_field("out_index", want.index,    result_bus.out_index);
                check_field("out_red",   want.red,      result_bus.out_red);
                check_field("out_green", want.green,    result_bus.out_green);
                check_field("out_blue",  want.blue,     result_bus.out_blue);
                check_field("luma",      want.luma,     result_bus.luma);
                check_field("chroma_u",  want.chroma_u, result_bus.chroma_u);
                check_field("chroma_v",  want.chroma_v, result_bus.chroma_v);
            end
        end
    end

    // Output side, back-pressure: random stalls, plus one long hold-off part-way through
    // so that the output register fills and the block has to refuse input.
    always @(negedge clk) begin
        if (!rst_n) begin
            result_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            result_bus.ready <= 1'b0;
            hold_left--;
        end else if (!hold_off_done && items_accepted >= HOLD_OFF_AT) begin
            hold_off_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES - 1;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= !idle_roll();
        end
    end

    // Watchdog: a long stretch with no transaction on either channel means a hang.
    always @(posedge clk) begin
        if (!rst_n || item_taken || result_taken) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("** palette_fade_engine: FAILED **");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int i;
        int k;

        clk                  = 1'b0;
        rst_n                = 1'b0;
        item_bus.valid       = 1'b0;
        item_bus.func        = FUNC_READ;
        item_bus.entry_index = '0;
        item_bus.red         = '0;
        item_bus.green       = '0;
        item_bus.blue        = '0;
        item_bus.steps_left  = '0;
        result_bus.ready     = 1'b0;
        items_accepted       = 0;
        results_taken        = 0;
        fail_count           = 0;
        quiet_cycles         = 0;
        hold_left            = 0;
        hold_off_done        = 1'b0;
        item_taken           = 1'b0;
        result_taken         = 1'b0;
        drain_placed         = 1'b0;

        // Both stores read as zero after reset.
        for (i = 0; i < ENTRIES; i++) begin
            for (k = 0; k < NUM_CH; k++) begin
                shade_mem[i][k] = '0;
                delta_mem[i][k] = '0;
            end
        end

        // Directed part. An untouched entry reads as black; then colours at the corners
        // of the range, which drive luma and both chroma terms to their extremes.
        add_op(FUNC_READ,  0,   0,   0,   0,   0);
        add_op(FUNC_WRITE, 0,   255, 255, 255, 255);
        add_op(FUNC_WRITE, 1,   255, 0,   0,   0);
        add_op(FUNC_WRITE, 2,   0,   0,   255, 0);
        add_op(FUNC_WRITE, 3,   0,   255, 0,   0);
        add_op(FUNC_WRITE, 255, 170, 85,  15,  0);
        add_op(FUNC_READ,  255, 0,   0,   0,   0);
        // A full-swing fade with the largest, an ordinary and a zero step count; the zero
        // count behaves as one and lands exactly on the target.
        add_op(FUNC_FADE_BEGIN, 3, 255, 0, 255, 0);
        add_op(FUNC_FADE_STEP,  3, 0,   0, 0,   255);
        add_op(FUNC_FADE_STEP,  3, 0,   0, 0,   3);
        add_op(FUNC_FADE_STEP,  3, 0,   0, 0,   0);
        add_op(FUNC_READ,       3, 0,   0, 0,   0);
        // A write in the middle of a fade keeps the difference, and the next step then
        // pushes a channel past the bottom of the range.
        add_op(FUNC_FADE_BEGIN, 1, 0,   255, 0,   1);
        add_op(FUNC_WRITE,      1, 0,   0,   255, 1);
        add_op(FUNC_FADE_STEP,  1, 0,   0,   0,   1);
        // The same toward the top of the range.
        add_op(FUNC_FADE_BEGIN, 2, 255, 255, 255, 2);
        add_op(FUNC_WRITE,      2, 128, 200, 255, 2);
        add_op(FUNC_FADE_STEP,  2, 0,   0,   0,   0);
        // A step on an entry with no fade pending changes nothing.
        add_op(FUNC_FADE_STEP,  4, 255, 255, 255, 1);
        add_op(FUNC_READ,       2, 255, 255, 255, 255);

        // Random part: mostly well-formed fades, the rest arbitrary operations.
        while (pending_ops.size() < 20 + RANDOM_OPS) begin
            if (!drain_placed && pending_ops.size() >= DRAIN_POINT) begin
                add_op(FUNC_READ, pick_entry(), any_byte(), any_byte(), any_byte(),
                       any_byte(), 1'b1);
                drain_placed = 1'b1;
            end else if ($urandom_range(3) == 0) begin
                add_op(t_func'($urandom_range(3)), pick_entry(), any_byte(), any_byte(),
                       any_byte(), any_byte());
            end else begin
                add_fade_run();
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && expected_views.size() == 0);
        // Any stray result would show up within this window.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("** palette_fade_engine: PASSED **");
        end else begin
            $display("** palette_fade_engine: FAILED **");
        end
        $finish;
    end

endmodule
